// File: rtl/tpwg_pkg.sv
// ----------------------------------------------------------------------------
// tpwg_pkg: shared constants and types
// Mode and register codes, mixer constants and the queue entry layout.
// ----------------------------------------------------------------------------
package tpwg_pkg;

	localparam int WORD_BYTES = 8;
	localparam int WORD_W     = 8 * WORD_BYTES;
	localparam int CNT_W      = 4;

	// payload modes
	localparam logic [1:0] MODE_RANDOM = 2'd0;
	localparam logic [1:0] MODE_ZERO   = 2'd1;
	localparam logic [1:0] MODE_ONES   = 2'd2;
	localparam logic [1:0] MODE_RAMP   = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_MODE   = 2'd0;
	localparam logic [1:0] REG_SEED   = 2'd1;
	localparam logic [1:0] REG_WORKER = 2'd2;

	// splitmix64 constants
	localparam logic [63:0] GOLDEN_GAMMA = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [63:0] MIX_MUL_A    = 64'hBF58_476D_1CE4_E5B9;
	localparam logic [63:0] MIX_MUL_B    = 64'h94D0_49BB_1331_11EB;
	localparam int          SHIFT_A      = 30;
	localparam int          SHIFT_B      = 27;
	localparam int          SHIFT_C      = 31;

	// ASCII ramp
	localparam logic [5:0] RAMP_LEN = 6'd26;
	localparam logic [7:0] CHAR_A   = 8'h41;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// one classified work item: either a state to be mixed or a finished pattern
	typedef struct packed {
		logic              is_rnd;
		logic [WORD_W-1:0] val;
		logic [CNT_W-1:0]  cnt;
	} entry_t;

	typedef struct packed {
		logic empty;
		logic full;
	} queue_status_t;

endpackage

// File: rtl/tpwg_front.sv
// ----------------------------------------------------------------------------
// tpwg_front: request intake
// Saturates the count, reloads/advances the generator state, tracks the
// ramp phase and builds one queue entry per accepted request.
// ----------------------------------------------------------------------------
module tpwg_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [1:0]            mode,
	input  logic [63:0]           reload,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  logic                  reseed,
	input  logic                  start_buffer,
	input  logic [3:0]            byte_count,
	input  tpwg_pkg::queue_status_t q_status,
	output logic                  push,
	output tpwg_pkg::entry_t      push_entry
);
	import tpwg_pkg::*;

	logic [63:0]      gen_state_q;
	logic [4:0]       ramp_phase_q;
	logic [CNT_W-1:0] cnt;
	logic [63:0]      st;
	logic [63:0]      st_adv;
	logic [4:0]       ph;
	logic [5:0]       ph_sum;
	logic [4:0]       ph_next;
	logic [63:0]      ramp_word;
	logic [5:0]       pos;
	logic             accept;

	assign req_ready = !q_status.full;
	assign accept    = req_valid && req_ready;
	assign push      = accept;

	assign cnt    = (byte_count > CNT_W'(WORD_BYTES)) ? CNT_W'(WORD_BYTES) : byte_count;
	assign st     = reseed ? reload : gen_state_q;
	assign st_adv = st + GOLDEN_GAMMA;
	assign ph     = start_buffer ? 5'd0 : ramp_phase_q;

	assign ph_sum  = {1'b0, ph} + {2'b00, cnt};
	assign ph_next = (ph_sum >= RAMP_LEN) ? 5'(ph_sum - RAMP_LEN) : ph_sum[4:0];

	always_comb begin
		ramp_word = '0;
		pos       = '0;
		for (int k = 0; k < WORD_BYTES; k++) begin
			pos = {1'b0, ph} + 6'(k);
			if (pos >= RAMP_LEN) begin
				pos = pos - RAMP_LEN;
			end
			ramp_word[8*k +: 8] = CHAR_A + {2'b00, pos};
		end
	end

	always_comb begin
		push_entry.cnt    = cnt;
		push_entry.is_rnd = 1'b0;
		unique case (mode)
			MODE_RANDOM: begin
				push_entry.is_rnd = 1'b1;
				push_entry.val    = st_adv;
			end
			MODE_ZERO: push_entry.val = '0;
			MODE_ONES: push_entry.val = '1;
			MODE_RAMP: push_entry.val = ramp_word;
			default:   push_entry.val = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_state_q  <= '0;
			ramp_phase_q <= '0;
		end else if (accept) begin
			gen_state_q  <= (mode == MODE_RANDOM) ? st_adv : st;
			ramp_phase_q <= ph_next;
		end
	end

endmodule

// File: rtl/tpwg_queue.sv
// ----------------------------------------------------------------------------
// tpwg_queue: small entry queue
// Decouples request intake from the mixing pipeline.
// ----------------------------------------------------------------------------
module tpwg_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  tpwg_pkg::entry_t        push_entry,
	input  logic                    pop,
	output tpwg_pkg::entry_t        head,
	output tpwg_pkg::queue_status_t status
);
	import tpwg_pkg::*;

	entry_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   fill_q;

	assign head         = mem_q[rd_ptr_q];
	assign status.empty = (fill_q == '0);
	assign status.full  = (fill_q == (QPTR_W+1)'(QUEUE_DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// File: rtl/tpwg_mix.sv
// ----------------------------------------------------------------------------
// tpwg_mix: splitmix64 finaliser and output stage
// Four stages: multiply, sum, multiply, sum/xor/mask into the output register.
// ----------------------------------------------------------------------------
module tpwg_mix (
	input  logic                     clk,
	input  logic                     arst_n,
	input  tpwg_pkg::entry_t         head,
	input  tpwg_pkg::queue_status_t  q_status,
	output logic                     pop,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [63:0]              out_word,
	output logic [3:0]               out_cnt
);
	import tpwg_pkg::*;

	logic        adv;
	logic [63:0] z1;
	logic [63:0] z2;
	logic [63:0] m1;
	logic [63:0] m2;
	logic [63:0] mixed;
	logic [63:0] word;
	logic [63:0] mask;

	logic        vld_s1, vld_s2, vld_s3;
	logic        rnd_s1, rnd_s2, rnd_s3;
	logic [63:0] val_s1, val_s2, val_s3;
	logic [3:0]  cnt_s1, cnt_s2, cnt_s3;
	logic [63:0] pll_s1, pll_s3;
	logic [31:0] phl_s1, plh_s1, phl_s3, plh_s3;
	logic [63:0] m_s2;

	logic        out_vld_q;
	logic [63:0] out_word_q;
	logic [3:0]  out_cnt_q;

	// the whole back end moves together unless a result is stuck at the output
	assign adv = !out_vld_q || out_ready;
	assign pop = adv && !q_status.empty;

	assign z1 = head.val ^ (head.val >> SHIFT_A);
	assign m1 = pll_s1 + {32'(phl_s1 + plh_s1), 32'd0};
	assign z2 = m_s2 ^ (m_s2 >> SHIFT_B);
	assign m2 = pll_s3 + {32'(phl_s3 + plh_s3), 32'd0};
	assign mixed = m2 ^ (m2 >> SHIFT_C);
	assign word  = rnd_s3 ? mixed : val_s3;

	always_comb begin
		for (int k = 0; k < WORD_BYTES; k++) begin
			mask[8*k +: 8] = (CNT_W'(k) < cnt_s3) ? 8'hFF : 8'h00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s1    <= !q_status.empty;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			out_vld_q <= vld_s3;
		end
	end

	// low 64 bits of a 64x64 product from three 32x32 partial products
	always_ff @(posedge clk) begin
		if (adv) begin
			rnd_s1 <= head.is_rnd;
			val_s1 <= head.val;
			cnt_s1 <= head.cnt;
			pll_s1 <= {32'd0, z1[31:0]} * {32'd0, MIX_MUL_A[31:0]};
			phl_s1 <= z1[63:32] * MIX_MUL_A[31:0];
			plh_s1 <= z1[31:0] * MIX_MUL_A[63:32];

			rnd_s2 <= rnd_s1;
			val_s2 <= val_s1;
			cnt_s2 <= cnt_s1;
			m_s2   <= m1;

			rnd_s3 <= rnd_s2;
			val_s3 <= val_s2;
			cnt_s3 <= cnt_s2;
			pll_s3 <= {32'd0, z2[31:0]} * {32'd0, MIX_MUL_B[31:0]};
			phl_s3 <= z2[63:32] * MIX_MUL_B[31:0];
			plh_s3 <= z2[31:0] * MIX_MUL_B[63:32];

			out_word_q <= word & mask;
			out_cnt_q  <= cnt_s3;
		end
	end

	assign out_valid = out_vld_q;
	assign out_word  = out_word_q;
	assign out_cnt   = out_cnt_q;

endmodule

// File: rtl/test_payload_word_generator_unit.sv
// ----------------------------------------------------------------------------
// test_payload_word_generator_unit: test payload word source
// Gives one 8-byte plaintext word per request: splitmix64, zeros, ones or
// an 'A'..'Z' ramp, with bytes past the requested count forced to zero.
//
// Usage:
//  - s_axis: one beat per request word. tdata holds reseed, start_buffer and
//    byte_count (counts above 8 are taken as 8).
//  - m_axis: one beat per request, in order. tdata holds the word (byte k in
//    bits 8k+7..8k) and the effective byte count.
//  - cfg: write-only registers (mode, seed, worker index), written while
//    the unit is idle; seed and worker reach requests via the reload register.
//  - From the edge that takes the input beat to the edge that can take its
//    output beat, a word passes the queue entry, three mix stages and the
//    output register. One word per cycle is sustained while m_axis does not
//    stall. The mix stages come from the two-multiply splitmix64 finaliser,
//    each 64-bit product built from three 32x32 partial products and summed
//    in the following stage.
//  - The generator state and ramp phase are updated at intake, so the
//    back end never feeds back into the front.
//  - A stalled m_axis freezes the back end; a four-entry queue keeps
//    s_axis accepting until it fills, then s_axis_tready drops.
//  - Reset clears registers, state, ramp phase and the queue; no output
//    beat is pending after reset.
// ----------------------------------------------------------------------------
module test_payload_word_generator_unit (
	input  logic        clk,
	input  logic        arst_n,
	// slave side
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [0] reseed, [1] start_buffer, [5:2] byte_count
	// master side
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,   // [63:0] data_word, [67:64] valid_bytes
	// configuration
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_addr,
	input  logic [63:0] cfg_wdata
);
	import tpwg_pkg::*;

	logic [1:0]    mode_q;
	logic [63:0]   seed_q;
	logic [15:0]   worker_q;
	logic [63:0]   reload_q;

	logic          push;
	entry_t        push_entry;
	entry_t        head;
	queue_status_t q_status;
	logic          pop;
	logic [63:0]   out_word;
	logic [3:0]    out_cnt;

	// configuration registers; index 3 is unmapped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_RANDOM;
			seed_q   <= '0;
			worker_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				REG_MODE:   mode_q   <= cfg_wdata[1:0];
				REG_SEED:   seed_q   <= cfg_wdata;
				REG_WORKER: worker_q <= cfg_wdata[15:0];
				default:    ;
			endcase
		end
	end

	// reload value seed + worker + 1, precomputed off the request path
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reload_q <= 64'd1;
		end else begin
			reload_q <= seed_q + {48'd0, worker_q} + 64'd1;
		end
	end

	tpwg_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.mode         (mode_q),
		.reload       (reload_q),
		.req_valid    (s_axis_tvalid),
		.req_ready    (s_axis_tready),
		.reseed       (s_axis_tdata[0]),
		.start_buffer (s_axis_tdata[1]),
		.byte_count   (s_axis_tdata[5:2]),
		.q_status     (q_status),
		.push         (push),
		.push_entry   (push_entry)
	);

	tpwg_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.status     (q_status)
	);

	tpwg_mix u_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_status  (q_status),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_word  (out_word),
		.out_cnt   (out_cnt)
	);

	assign m_axis_tdata = {4'd0, out_cnt, out_word};

endmodule

// File: rtl/tpwg_checker.sv
// ----------------------------------------------------------------------------
// tpwg_checker: port-level checks
// Watches the output stream of the payload word generator.
// ----------------------------------------------------------------------------
module tpwg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [71:0] m_axis_tdata
);

	// a held beat keeps its payload
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output beat changed while stalled");

	// count never exceeds one word
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[67:64] <= 4'd8)
		else $error("valid_bytes above 8");

	// top byte only carries data when the word is full
	a_tail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[63:56] == 8'd0 || m_axis_tdata[67:64] == 4'd8)
		else $error("unused top byte not zero");

	// empty word is all zero
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[67:64] == 4'd0 |-> m_axis_tdata[63:0] == 64'd0)
		else $error("zero-count word carries data");

endmodule

bind test_payload_word_generator_unit tpwg_checker u_tpwg_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// File: test/payload_word_checker.sv
// ----------------------------------------------------------------------------
// payload_word_checker: prediction and comparison for the payload generator
// Follows config writes and request beats, predicts every output word and
// compares each output beat in order against the oldest prediction.
// ----------------------------------------------------------------------------
module payload_word_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [0] reseed, [1] start_buffer, [5:2] byte_count
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [71:0] m_axis_tdata,   // [63:0] data_word, [67:64] valid_bytes
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_addr,
	input  logic [63:0] cfg_wdata,
	output int          errors,
	output int          pending
);
	import tpwg_pkg::*;

	typedef struct packed {
		logic [WORD_W-1:0] data_word;
		logic [CNT_W-1:0]  valid_bytes;
	} payload_t;

	payload_t expected_words[$];

	logic [1:0]        mode;
	logic [63:0]       seed;
	logic [15:0]       worker;
	logic [63:0]       mix_state;
	int                ramp_pos;

	function automatic logic [63:0] finalise(input logic [63:0] s);
		logic [63:0] z;
		z = s;
		z = (z ^ (z >> SHIFT_A)) * MIX_MUL_A;
		z = (z ^ (z >> SHIFT_B)) * MIX_MUL_B;
		return z ^ (z >> SHIFT_C);
	endfunction

	// advances generator state and ramp position as the block does at intake
	function automatic payload_t predict_word(input logic [7:0] req);
		payload_t    p;
		int          cnt;
		logic [63:0] word;
		cnt  = int'(req[5:2]);
		word = '0;
		if (cnt > WORD_BYTES)
			cnt = WORD_BYTES;
		if (req[0])
			mix_state = seed + {48'd0, worker} + 64'd1;
		if (req[1])
			ramp_pos = 0;
		if (ramp_pos >= int'(RAMP_LEN))
			ramp_pos = 0;
		case (mode)
			MODE_RANDOM: begin
				mix_state = mix_state + GOLDEN_GAMMA;
				word = finalise(mix_state);
			end
			MODE_ONES: word = '1;
			MODE_RAMP: begin
				for (int k = 0; k < WORD_BYTES; k++)
					word[8*k +: 8] = CHAR_A + 8'((ramp_pos + k) % int'(RAMP_LEN));
			end
			default: word = '0;
		endcase
		for (int k = 0; k < WORD_BYTES; k++)
			if (k >= cnt)
				word[8*k +: 8] = 8'h00;
		ramp_pos = (ramp_pos + cnt) % int'(RAMP_LEN);
		p.data_word   = word;
		p.valid_bytes = CNT_W'(cnt);
		return p;
	endfunction

	task automatic note_mismatch(input string what, input logic [63:0] exp_v,
			input logic [63:0] got_v);
		if (errors < 10)
			$display("mismatch %s: expected %h, got %h at %0t", what, exp_v, got_v,
				$realtime);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		payload_t want;
		if (!arst_n) begin
			mode      = MODE_RANDOM;
			seed      = '0;
			worker    = '0;
			mix_state = '0;
			ramp_pos  = 0;
			expected_words.delete();
			errors    = 0;
			pending   = 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_addr)
					REG_MODE:   mode   = cfg_wdata[1:0];
					REG_SEED:   seed   = cfg_wdata;
					REG_WORKER: worker = cfg_wdata[15:0];
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_words.size() == 0) begin
					note_mismatch("unexpected beat", '0, m_axis_tdata[63:0]);
				end else begin
					want = expected_words.pop_front();
					if (m_axis_tdata[63:0] !== want.data_word)
						note_mismatch("data_word", want.data_word, m_axis_tdata[63:0]);
					if (m_axis_tdata[67:64] !== want.valid_bytes)
						note_mismatch("valid_bytes", 64'(want.valid_bytes),
							64'(m_axis_tdata[67:64]));
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_words.push_back(predict_word(s_axis_tdata));
			pending = expected_words.size();
		end
	end

endmodule

// File: test/test_payload_word_generator_unit_test.sv
// ----------------------------------------------------------------------------
// test_payload_word_generator_unit_test: payload generator testbench
// Directed requests over every mode and corner, then randomised buffers
// under changing register settings, with random idle on both streams.
// ----------------------------------------------------------------------------
module test_payload_word_generator_unit_test;
	import tpwg_pkg::*;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [71:0] m_axis_tdata;
	logic        cfg_wr_en     = 1'b0;
	logic [1:0]  cfg_addr      = REG_MODE;
	logic [63:0] cfg_wdata     = '0;

	int errors;
	int pending;

	// when set, neither side idles: back-to-back beats
	bit no_idle = 1'b0;
	int sent    = 0;

	test_payload_word_generator_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	payload_word_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.errors        (errors),
		.pending       (pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int draw_gap();
		return no_idle ? 0 : $urandom_range(0, 14);
	endfunction

	// one request beat; returns in the time step of the accepting edge
	// with tvalid still high, so a back-to-back beat needs no second edit
	task automatic send_req(input bit reseed, input bit start, input int cnt);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {2'b00, 4'(cnt), start, reseed};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sent++;
	endtask

	// drop tvalid and wait for every predicted word to come back; the extra
	// wait covers the take-up of a register write through the reload register
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] addr, input logic [63:0] data);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_addr  <= addr;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		repeat (3) @(posedge clk);
	endtask

	// sink: random stall before each beat, held ready until one is taken
	initial begin : sink
		int gap;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			gap = draw_gap();
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
		end
	end

	// generous bound: worst case is far below this
	initial begin : watchdog
		#5_000_000;
		$display("[test_payload_word_generator_unit] ERROR");
		$finish;
	end

	initial begin : stimulus
		int          ph;
		int          rem;
		int          cnt;
		int          roll;
		logic [1:0]  mode;
		logic [63:0] seed;
		logic [15:0] worker;
		bit          first;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// --- directed part ---
		// random mode straight out of reset: state starts at zero
		send_req(1'b0, 1'b1, 8);
		send_req(1'b0, 1'b0, 0);   // zero count still advances the state
		send_req(1'b0, 1'b0, 15);  // count above eight saturates
		send_req(1'b0, 1'b0, 1);

		// seed and worker at their maxima: reseed sum wraps
		write_reg(REG_SEED, '1);
		write_reg(REG_WORKER, 64'hFFFF);
		send_req(1'b1, 1'b1, 8);
		send_req(1'b0, 1'b0, 9);

		// reseed outside random mode reloads but does not advance
		write_reg(REG_MODE, 64'(MODE_ZERO));
		send_req(1'b0, 1'b1, 8);
		send_req(1'b1, 1'b0, 5);
		send_req(1'b0, 1'b0, 3);
		write_reg(REG_MODE, 64'(MODE_RANDOM));
		send_req(1'b0, 1'b0, 8);

		write_reg(REG_MODE, 64'(MODE_ONES));
		send_req(1'b0, 1'b1, 8);
		send_req(1'b0, 1'b0, 0);
		send_req(1'b0, 1'b0, 1);
		send_req(1'b1, 1'b0, 12);

		// ramp: phase wraps past 'Z', restarts on start_buffer
		write_reg(REG_MODE, 64'(MODE_RAMP));
		send_req(1'b0, 1'b1, 8);
		send_req(1'b0, 1'b0, 8);
		send_req(1'b0, 1'b0, 8);
		send_req(1'b0, 1'b0, 3);
		send_req(1'b0, 1'b1, 7);
		send_req(1'b0, 1'b0, 15);
		send_req(1'b0, 1'b0, 0);
		send_req(1'b0, 1'b0, 8);

		// --- random part: buffers under a fresh setting per phase ---
		ph = 0;
		while (sent < 1060) begin
			mode = (ph < 8) ? 2'(ph % 4) : 2'($urandom_range(0, 3));
			case (ph % 5)
				0: seed = '0;
				1: seed = '1;
				default: seed = {$urandom, $urandom};
			endcase
			case (ph % 3)
				0: worker = 16'hFFFF;
				1: worker = '0;
				default: worker = 16'($urandom);
			endcase
			write_reg(REG_MODE, 64'(mode));
			write_reg(REG_SEED, seed);
			write_reg(REG_WORKER, 64'(worker));
			no_idle = ($urandom_range(0, 3) == 0);

			repeat (30) begin
				roll = $urandom_range(0, 99);
				if (roll < 85) begin
					// well-formed buffer: full words, short tail, start on first
					rem   = $urandom_range(1, 60);
					first = 1'b1;
					while (rem > 0) begin
						cnt = (rem > 8) ? 8 : rem;
						send_req(first && ($urandom_range(0, 2) == 0), first, cnt);
						first = 1'b0;
						rem   = rem - cnt;
					end
				end else begin
					// noise: any flags, any count including 0 and 9..15
					send_req(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
						$urandom_range(0, 15));
				end
			end
			ph++;
		end

		wait_idle();
		repeat (20) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("[test_payload_word_generator_unit] OK");
		end else begin
			$display("[test_payload_word_generator_unit] ERROR");
		end
		$finish;
	end

endmodule
